// ===== sv/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/vsl_pkg.sv =====
// Package for the variable-step low-pass filter: widths, codes, types.
// No dependencies; used by the interfaces, the divider and the top level.
package vsl_pkg;

    localparam int IDX_W            = 6;
    localparam int VAL_W            = 32;
    localparam int TS_W             = 48;
    localparam int TAU_W            = 32;
    localparam int THR_W            = 20;
    localparam int FRAC_W           = 16;
    localparam int ALPHA_W          = FRAC_W + 1;
    localparam int NUM_ELEMENTS_DEF = 64;

    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1000);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_SETTING = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_EMIT
    } vsl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vsl_div_stat_t;

endpackage

// ===== sv/vsl_in_if.sv =====
// Input channel of the filter: valid/ready handshake and one element word.
// Depends on vsl_pkg for field widths.
interface vsl_in_if;
    import vsl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] sample_value;
    logic [TS_W-1:0]         time_stamp_us;
    logic                    vector_end;
    logic [TAU_W-1:0]        time_constant_us;
    logic                    enable_filter;

    modport source (
        output valid, req_type, element_index, sample_value, time_stamp_us,
               vector_end, time_constant_us, enable_filter,
        input  ready
    );

    modport sink (
        input  valid, req_type, element_index, sample_value, time_stamp_us,
               vector_end, time_constant_us, enable_filter,
        output ready
    );
endinterface

// ===== sv/vsl_out_if.sv =====
// Output channel of the filter: valid/ready handshake and one result word.
// Depends on vsl_pkg for field widths.
interface vsl_out_if;
    import vsl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    was_filtered;
    logic                    out_last;

    modport source (
        output valid, out_index, out_value, was_filtered, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_value, was_filtered, out_last,
        output ready
    );
endinterface

// ===== sv/vsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsl_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/vsl_div.sv =====
// Radix-2 restoring divider for the smoothing factor dt*2^16/(dt+tau).
// Depends on vsl_pkg; one quotient bit per cycle, 17 quotient bits per division.
module vsl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vsl_pkg::TS_W-1:0]      dt,
    input  logic [vsl_pkg::TAU_W-1:0]     tau,
    output vsl_pkg::vsl_div_stat_t        stat,
    output logic [vsl_pkg::ALPHA_W-1:0]   quotient
);
    import vsl_pkg::*;

    localparam int DEN_W = TS_W + 1;
    localparam int REM_W = TS_W + FRAC_W;
    localparam int DVS_W = DEN_W + FRAC_W;
    localparam int CNT_W = $clog2(ALPHA_W);

    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg;
    logic [ALPHA_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [DEN_W-1:0]   den;
    logic               fits;

    assign den  = {1'b0, dt} + DEN_W'(tau);
    assign fits = {1'b0, rem_reg} >= dvs_reg;

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = {q_reg[ALPHA_W-2:0], fits};
        if (fits)
        begin
            rem_next = REM_W'({1'b0, rem_reg} - dvs_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(ALPHA_W - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {dt, FRAC_W'(0)};
            dvs_reg <= {den, FRAC_W'(0)};
            q_reg   <= (den == '0) ? ALPHA_ONE : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
endmodule

// ===== sv/variable_step_first_order_lowpass_top.sv =====
// Sample word: after accept the states run LOOKUP, DIV, MUL, UPD and EMIT when the
// element's filter is enabled, or LOOKUP and EMIT when raw; EMIT waits for a free output
// register, then the next word is taken in IDLE; DIV waits on the 17-step divider.
// Setting words give no result. Reset (rst_n low, asynchronous) starts a clearing pass
// over both tables; no word is accepted until it ends. Threshold resets to 1000 us.
// Depends on vsl_pkg, vsl_in_if, vsl_out_if, vsl_ram, vsl_div, assert_macros.svh.
`include "assert_macros.svh"

module variable_step_first_order_lowpass_top #(
    parameter int NUM_ELEMENTS = vsl_pkg::NUM_ELEMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [vsl_pkg::THR_W-1:0] cfg_wr_data,
    vsl_in_if.sink                    samples,
    vsl_out_if.source                 results
);
    import vsl_pkg::*;

    localparam int AW    = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int TC_W  = TAU_W + 1;
    localparam int DIF_W = VAL_W + 1;
    localparam int PRD_W = ALPHA_W + 1 + DIF_W;

    vsl_state_t state_reg, state_next;

    logic [AW-1:0]           clr_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [TS_W-1:0]         last_ts_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] x_reg;
    logic                    vend_reg;
    logic [TS_W-1:0]         dt_reg, dt_next;
    logic                    past_reg;
    logic                    range_reg;
    logic signed [VAL_W-1:0] yp_reg;
    logic signed [DIF_W-1:0] diff_reg;
    logic [ALPHA_W-1:0]      alpha_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0] res_val_reg;
    logic                    res_filt_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic                    out_filt_reg;
    logic                    out_last_reg;

    logic                    accept;
    logic                    in_range;
    logic                    use_filter;
    logic                    out_free;
    logic signed [VAL_W-1:0] y_new;

    logic                    tc_we;
    logic [AW-1:0]           tc_waddr;
    logic [TC_W-1:0]         tc_wdata;
    logic [TC_W-1:0]         tc_rdata;
    logic                    y_we;
    logic [AW-1:0]           y_waddr;
    logic [VAL_W-1:0]        y_wdata;
    logic [VAL_W-1:0]        y_rdata;
    logic [AW-1:0]           raddr;

    logic                    div_start;
    vsl_div_stat_t           div_stat;
    logic [ALPHA_W-1:0]      div_q;

    assign accept     = samples.valid && samples.ready;
    assign in_range   = int'(samples.element_index) < NUM_ELEMENTS;
    assign raddr      = AW'(samples.element_index);
    assign use_filter = range_reg && tc_rdata[TAU_W];
    assign out_free   = !out_valid_reg || results.ready;
    assign dt_next    = (samples.time_stamp_us >= last_ts_reg) ?
                        samples.time_stamp_us - last_ts_reg : '0;
    assign y_new      = yp_reg + VAL_W'(prod_reg >>> FRAC_W);

    vsl_ram #(.WIDTH(TC_W), .DEPTH(NUM_ELEMENTS)) u_tc_ram (
        .clk   (clk),
        .we    (tc_we),
        .waddr (tc_waddr),
        .wdata (tc_wdata),
        .raddr (raddr),
        .rdata (tc_rdata)
    );

    vsl_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .raddr (raddr),
        .rdata (y_rdata)
    );

    vsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dt       (dt_reg),
        .tau      (tc_rdata[TAU_W-1:0]),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        div_start     = 1'b0;
        tc_we         = 1'b0;
        tc_waddr      = raddr;
        tc_wdata      = {samples.enable_filter, samples.time_constant_us};
        y_we          = 1'b0;
        y_waddr       = AW'(idx_reg);
        y_wdata       = y_new;
        case (state_reg)
            ST_CLEAR:
            begin
                tc_we    = 1'b1;
                tc_waddr = clr_reg;
                tc_wdata = '0;
                y_we     = 1'b1;
                y_waddr  = clr_reg;
                y_wdata  = '0;
                if (clr_reg == AW'(NUM_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (accept)
                begin
                    if (samples.req_type == REQ_SETTING)
                    begin
                        tc_we = in_range;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                div_start  = use_filter;
                state_next = use_filter ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                y_we       = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            thr_reg       <= THR_RESET;
            last_ts_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (accept && samples.req_type == REQ_SAMPLE && samples.vector_end)
            begin
                last_ts_reg <= samples.time_stamp_us;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg   <= samples.element_index;
                x_reg     <= samples.sample_value;
                vend_reg  <= samples.vector_end;
                dt_reg    <= dt_next;
                range_reg <= in_range;
                past_reg  <= samples.time_stamp_us >= TS_W'(thr_reg);
            end
            ST_LOOKUP:
            begin
                yp_reg       <= $signed(y_rdata);
                diff_reg     <= DIF_W'(x_reg) - DIF_W'($signed(y_rdata));
                res_val_reg  <= x_reg;
                res_filt_reg <= 1'b0;
            end
            ST_DIV:
            begin
                alpha_reg <= div_q;
            end
            ST_MUL:
            begin
                prod_reg <= $signed({1'b0, alpha_reg}) * diff_reg;
            end
            ST_UPD:
            begin
                res_val_reg  <= past_reg ? y_new : x_reg;
                res_filt_reg <= past_reg;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_idx_reg  <= idx_reg;
                    out_val_reg  <= res_val_reg;
                    out_filt_reg <= res_filt_reg;
                    out_last_reg <= vend_reg;
                end
            end
            default:
            begin
                alpha_reg <= alpha_reg;
            end
        endcase
    end

    assign results.valid        = out_valid_reg;
    assign results.out_index    = out_idx_reg;
    assign results.out_value    = out_val_reg;
    assign results.was_filtered = out_filt_reg;
    assign results.out_last     = out_last_reg;

    `ASSERT_CLK(a_div_in_div_state, (div_stat.busy || div_stat.done) |-> state_reg == ST_DIV, "divider active outside division state")
    `ASSERT_CLK(a_y_write_state, y_we |-> (state_reg == ST_UPD || state_reg == ST_CLEAR), "filter memory written outside update or clear")
    `ASSERT_CLK(a_result_from_emit, $rose(results.valid) |-> $past(state_reg) == ST_EMIT, "result word raised without emit")
    `ASSERT_NEXT(a_setting_no_result, accept && samples.req_type == REQ_SETTING, state_reg == ST_IDLE, "setting word left idle")
endmodule
